@@ design/krv_pkg.sv @@
// Shared constants and types for the keyed completion rendezvous block.
`default_nettype none
package krv_pkg;
    localparam int KEY_W           = 32;
    localparam int CNT_W           = 6;
    localparam int EXP_W           = 7;
    localparam int DEFAULT_ENTRIES = 16;

    localparam logic [EXP_W-1:0] EXP_ONE   = EXP_W'(1);
    localparam logic [EXP_W-1:0] EXP_MAX   = EXP_W'(64);
    localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(1);

    typedef struct packed {
        logic fire;
        logic full;
    } t_report_status;
endpackage
`default_nettype wire

@@ design/krv_table.sv @@
// Associative key table: parallel lookup, lowest-free allocation and count update.
`default_nettype none
module krv_table
    import krv_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [EXP_W-1:0] i_expect,
    output t_report_status        o_status
);
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]         r_key   [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_count [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [TABLE_ENTRIES-1:0] hit_oh;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [CNT_W-1:0]         hit_count;
    logic [EXP_W-1:0]         n_count;
    logic                     any_hit;
    logic                     full;
    logic                     done;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == i_key);
        end
    end

    assign free_vec = ~r_valid;
    assign hit_oh   = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
    assign free_oh  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    assign any_hit  = |hit_vec;
    assign full     = ~|free_vec;

    always_comb begin
        hit_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_count = hit_count | (r_count[i] & {CNT_W{hit_oh[i]}});
        end
    end

    assign n_count = {1'b0, hit_count} + EXP_ONE;
    assign done    = n_count >= i_expect;

    assign o_status.fire = any_hit && done;
    assign o_status.full = !any_hit && full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (any_hit) begin
                    if (hit_oh[i] && done) begin
                        r_valid[i] <= 1'b0;
                    end
                end else if (free_oh[i]) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (any_hit) begin
                    if (hit_oh[i]) begin
                        r_count[i] <= n_count[CNT_W-1:0];
                    end
                end else if (free_oh[i]) begin
                    r_key[i]   <= i_key;
                    r_count[i] <= CNT_W'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ design/keyed_completion_rendezvous.sv @@
// Top level: report input register, expected-count register and result register.
// An accepted report is held in the input register, then looked up and its outcome taken in
// the result register. Throughput: one report per cycle; busy is never raised and the
// receiver cannot stall; lookup and update are one pass of compare logic between registers.
// Reset: synchronous, active low; clears the table valid bits, the pending
// report, the result strobe and sets the expected count to 1.
`default_nettype none
module keyed_completion_rendezvous
    import krv_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [KEY_W-1:0] i_block_number,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [EXP_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_fire,
    output logic [KEY_W-1:0]      o_fired_block,
    output logic                  o_table_full
);
    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [EXP_W-1:0] r_expect;
    logic             r_done;
    logic             r_fire;
    logic [KEY_W-1:0] r_fired_block;
    logic             r_full;

    logic [EXP_W-1:0] eff_expect;
    logic             bypass;
    logic             n_fire;
    t_report_status   status;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_expect == '0) begin
            eff_expect = EXP_ONE;
        end else if (r_expect > EXP_MAX) begin
            eff_expect = EXP_MAX;
        end else begin
            eff_expect = r_expect;
        end
    end

    assign bypass = eff_expect == EXP_ONE;

    krv_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req && !bypass),
        .i_key   (r_key),
        .i_expect(eff_expect),
        .o_status(status)
    );

    assign n_fire = bypass || status.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req    <= 1'b0;
            r_done   <= 1'b0;
            r_expect <= EXP_RESET;
        end else begin
            r_req  <= start && !busy;
            r_done <= r_req;
            if (i_cfg_valid && o_cfg_ready) begin
                r_expect <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_key <= i_block_number;
        end
        if (r_req) begin
            r_fire        <= n_fire;
            r_fired_block <= n_fire ? r_key : '0;
            r_full        <= !bypass && status.full;
        end
    end

    assign o_done        = r_done;
    assign o_fire        = r_fire;
    assign o_fired_block = r_fired_block;
    assign o_table_full  = r_full;

`ifndef SYNTHESIS
    a_fire_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_fire && o_table_full))
        else $error("fire and table_full both set");
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted item gave no result strobe");
    a_bypass_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req && bypass) |=> (o_fire && !o_table_full))
        else $error("unit expected count did not fire");
    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_fire) |-> (o_fired_block == '0))
        else $error("fired_block nonzero without fire");
`endif
endmodule
`default_nettype wire

@@ bench/krv_checker.sv @@
// Checker: tracks the per-key report table, predicts each report's outcome and compares results.
`default_nettype none
module krv_checker
    import krv_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic [KEY_W-1:0] i_block_number,
    input  wire logic             i_cfg_valid,
    input  wire logic             o_cfg_ready,
    input  wire logic [EXP_W-1:0] i_cfg_data,
    input  wire logic             o_done,
    input  wire logic             o_fire,
    input  wire logic [KEY_W-1:0] o_fired_block,
    input  wire logic             o_table_full,
    output int                    o_err_count,
    output int                    o_pending
);

    typedef struct packed {
        logic             fire;
        logic [KEY_W-1:0] block;
        logic             full;
    } t_outcome;

    logic [EXP_W-1:0] expected_reg;
    logic             slot_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0] slot_key   [TABLE_ENTRIES];
    logic [CNT_W-1:0] slot_count [TABLE_ENTRIES];
    t_outcome         outcome_q  [$];
    int               errs = 0;

    function automatic logic [EXP_W-1:0] reports_needed(input logic [EXP_W-1:0] r);
        if (r == '0) return EXP_ONE;
        if (r > EXP_MAX) return EXP_MAX;
        return r;
    endfunction

    function automatic t_outcome resolve_report(input logic [KEY_W-1:0] key);
        t_outcome         res;
        logic [EXP_W-1:0] need;
        logic [EXP_W-1:0] cnt;
        int               hit;
        int               free_slot;
        res       = '0;
        need      = reports_needed(expected_reg);
        hit       = -1;
        free_slot = -1;
        if (need == EXP_ONE) begin
            res.fire  = 1'b1;
            res.block = key;
            return res;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                if (slot_key[i] == key && hit < 0) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit >= 0) begin
            cnt = EXP_W'(slot_count[hit]) + EXP_W'(1);
            // lowered count: fires as soon as it is reached or passed
            if (cnt >= need) begin
                slot_valid[hit] = 1'b0;
                slot_count[hit] = '0;
                res.fire        = 1'b1;
                res.block       = key;
            end else begin
                slot_count[hit] = CNT_W'(cnt);
            end
        end else if (free_slot < 0) begin
            res.full = 1'b1;
        end else begin
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_count[free_slot] = CNT_W'(1);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (!i_rst_n) begin
            expected_reg = EXP_RESET;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_count[i] = '0;
            end
            outcome_q.delete();
        end else begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result: fire %0b fired_block %h table_full %0b",
                           o_fire, o_fired_block, o_table_full);
                    errs++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_fire !== want.fire) begin
                        $error("fire: expected %0b, actual %0b", want.fire, o_fire);
                        errs++;
                    end
                    if (o_fired_block !== want.block) begin
                        $error("fired_block: expected %h, actual %h", want.block, o_fired_block);
                        errs++;
                    end
                    if (o_table_full !== want.full) begin
                        $error("table_full: expected %0b, actual %0b", want.full, o_table_full);
                        errs++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) expected_reg = i_cfg_data;
            if (start && !busy) outcome_q.push_back(resolve_report(i_block_number));
        end
        o_err_count <= errs;
        o_pending   <= outcome_q.size();
    end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench top: drives completion reports and count settings, watchdog and final verdict.
`default_nettype none
module tb;
    import krv_pkg::*;

    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    // any open entry fires on its next report at this setting
    localparam logic [EXP_W-1:0] CLOSE_EXPECTED = EXP_W'(2);

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [KEY_W-1:0] i_block_number;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [EXP_W-1:0] i_cfg_data;
    logic             o_done;
    logic             o_fire;
    logic [KEY_W-1:0] o_fired_block;
    logic             o_table_full;

    int               err_count;
    int               pending;
    int               quiet_cycles = 0;
    int               idle_pct = 0;
    int               burst_left = 0;
    logic             last_fire = 1'b0;
    logic             last_full = 1'b0;
    logic [KEY_W-1:0] phase_keys [$];
    int               phase_settings [$] = '{2, 4, 1, 64, 3, 127, 0, 2, 6, 65, 8, 3};
    int               idle_modes [$] = '{0, 86, 32};

    keyed_completion_rendezvous dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_block_number (i_block_number),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_fire         (o_fire),
        .o_fired_block  (o_fired_block),
        .o_table_full   (o_table_full)
    );

    krv_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_block_number (i_block_number),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_fire         (o_fire),
        .o_fired_block  (o_fired_block),
        .o_table_full   (o_table_full),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_done) begin
            last_fire <= o_fire;
            last_full <= o_table_full;
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_report(input logic [KEY_W-1:0] key);
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(19) == 0) begin
            burst_left = $urandom_range(12, 4);
        end else begin
            while ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_block_number <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_expected(input logic [EXP_W-1:0] value);
        wait_quiet();
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one report per key closes an open entry; a fresh allocation takes a second
    task automatic close_open_keys();
        write_expected(CLOSE_EXPECTED);
        foreach (phase_keys[i]) begin
            send_report(phase_keys[i]);
            wait_quiet();
            if (!last_fire && !last_full) begin
                send_report(phase_keys[i]);
                wait_quiet();
            end
        end
        phase_keys.delete();
    endtask

    task automatic run_phase(input logic [EXP_W-1:0] setting, input int count);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        write_expected(setting);
        pool_size = (setting >= 16) ? $urandom_range(3, 1) : $urandom_range(22, 4);
        repeat (pool_size) begin
            key = $urandom();
            pool.push_back(key);
            phase_keys.push_back(key);
        end
        repeat (count) begin
            if ($urandom_range(39) == 0) wait_quiet();
            if ($urandom_range(99) < 85) begin
                key = pool[$urandom_range(pool.size() - 1)];
            end else begin
                key = $urandom();
                phase_keys.push_back(key);
            end
            send_report(key);
        end
        close_open_keys();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_block_number <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of one: every report fires
        send_report('0);
        send_report('1);
        // zero count behaves as one
        write_expected('0);
        send_report(32'h5555_5555);
        send_report(32'hAAAA_AAAA);
        write_expected(EXP_W'(3));
        repeat (3) send_report(32'h1234_5678);
        for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
            send_report(32'h8000_0000 + i);
            phase_keys.push_back(32'h8000_0000 + i);
        end
        // table full: new key dropped
        send_report(32'h7FFF_FFFF);
        // count lowered with entries open
        close_open_keys();

        foreach (phase_settings[p]) begin
            idle_pct = idle_modes[p % idle_modes.size()];
            run_phase(EXP_W'(phase_settings[p]), (phase_settings[p] >= 16) ? 70 : 30);
        end

        wait_quiet();
        repeat (LATENCY * 4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
